/* rtl/core/fat12w_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the FAT12 cluster chain sector walker.
// No dependencies; in rtl/core, fat12w_ctrl, fat12w_dp and the walker top import this package.
package fat12w_pkg;

	localparam int TABLE_BYTES_DEF = 8192;
	localparam int CFG_W           = 32;
	localparam int CFG_IDX_W       = 1;

	localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPC        = 1'd1;

	localparam logic [31:0] DATA_START_RST = 32'd33;
	localparam logic [7:0]  SPC_RST        = 8'd1;
	localparam logic [7:0]  SPC_MAX        = 8'd128;

	localparam logic [11:0] END_MARK   = 12'hFF8;
	localparam logic [15:0] ENTRY_MASK = 16'h0FFF;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_START   = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [12:0] table_addr;
		logic [7:0]  table_byte;
		logic [11:0] start_cluster;
	} in_word_t;

	typedef struct packed {
		logic [31:0] sector_lba;
		logic [11:0] cluster_now;
		logic        end_of_chain;
	} out_word_t;

	typedef struct packed {
		logic write_tbl;
		logic do_start;
		logic sec_inc;
		logic sec_clr;
		logic rd_lo;
		logic rd_hi;
		logic take_next;
		logic mul;
		logic sum;
		logic lba_clr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       start_end;
		logic       ended;
		logic       wrap;
		logic       next_end;
		logic       out_busy;
	} sts_t;

endpackage

/* rtl/core/fat12w_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fat12w_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/fat12w_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the walker: decodes each accepted word and steps the datapath.
// Depends on fat12w_pkg.
module fat12w_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fat12w_pkg::sts_t  sts,
	output fat12w_pkg::cmd_t  cmd
);
	import fat12w_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD_LO = 7'b0000010,
		S_RD_HI = 7'b0000100,
		S_NEXT  = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_SUM   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (sts.op)
						OP_LOAD: begin
							cmd.write_tbl = 1'b1;
							cmd.lba_clr   = 1'b1;
							state_d       = S_DONE;
						end
						OP_START: begin
							cmd.do_start = 1'b1;
							if (sts.start_end) begin
								cmd.lba_clr = 1'b1;
								state_d     = S_DONE;
							end else begin
								state_d = S_MUL;
							end
						end
						OP_ADVANCE: begin
							if (sts.ended) begin
								cmd.lba_clr = 1'b1;
								state_d     = S_DONE;
							end else if (sts.wrap) begin
								cmd.sec_clr = 1'b1;
								state_d     = S_RD_LO;
							end else begin
								cmd.sec_inc = 1'b1;
								state_d     = S_MUL;
							end
						end
						default: begin
							cmd.lba_clr = 1'b1;
							state_d     = S_DONE;
						end
					endcase
				end
			end
			S_RD_LO: begin
				cmd.rd_lo = 1'b1;
				state_d   = S_RD_HI;
			end
			S_RD_HI: begin
				cmd.rd_hi = 1'b1;
				state_d   = S_NEXT;
			end
			S_NEXT: begin
				cmd.take_next = 1'b1;
				if (sts.next_end) begin
					cmd.lba_clr = 1'b1;
					state_d     = S_DONE;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/fat12w_dp.sv */
`timescale 1ns / 1ps
// Walker datapath: config registers, table RAM, chain state, LBA math, output register.
// Depends on fat12w_pkg and fat12w_ram.
module fat12w_dp #(
	parameter int TABLE_BYTES = fat12w_pkg::TABLE_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fat12w_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fat12w_pkg::CFG_W-1:0]         cfg_wdata,
	input  fat12w_pkg::in_word_t                 in_data,
	input  fat12w_pkg::cmd_t                     cmd,
	output fat12w_pkg::sts_t                     sts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output fat12w_pkg::out_word_t                out_data
);
	import fat12w_pkg::*;

	localparam int AW = $clog2(TABLE_BYTES);

	logic [31:0] dsl_q;
	logic [7:0]  spc_q;
	logic [7:0]  eff_spc;
	logic [11:0] cur_q;
	logic [6:0]  sic_q;
	logic        ended_q;
	logic [31:0] prod_q;
	logic [31:0] lba_q;
	logic [7:0]  lo_q;
	logic        rd_ok_q;
	logic        out_valid_q;
	out_word_t   out_q;

	logic [13:0] at_lo;
	logic [13:0] at_hi;
	logic [13:0] rd_at;
	logic        rd_ok;
	logic        wr_ok;
	logic [7:0]  rbyte;
	logic [7:0]  ram_rdata;
	logic [15:0] pair;
	logic [11:0] next_cl;
	logic [31:0] cl_off;
	logic [31:0] mul_full;

	always_comb begin
		if (spc_q == 8'd0) begin
			eff_spc = 8'd1;
		end else if (spc_q > SPC_MAX) begin
			eff_spc = SPC_MAX;
		end else begin
			eff_spc = spc_q;
		end
	end

	// entry offset = cluster * 3 / 2
	assign at_lo = (14'(cur_q) + 14'(cur_q >> 1));
	assign at_hi = at_lo + 14'd1;
	assign rd_at = cmd.rd_hi ? at_hi : at_lo;
	assign rd_ok = 32'(rd_at) < 32'(TABLE_BYTES);
	assign wr_ok = 32'(in_data.table_addr) < 32'(TABLE_BYTES);

	fat12w_ram #(
		.W     (8),
		.DEPTH (TABLE_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.write_tbl & wr_ok),
		.waddr (AW'(32'(in_data.table_addr))),
		.wdata (in_data.table_byte),
		.re    (cmd.rd_lo | cmd.rd_hi),
		.raddr (AW'(32'(rd_at))),
		.rdata (ram_rdata)
	);

	assign rbyte = rd_ok_q ? ram_rdata : 8'd0;
	assign pair  = {rbyte, lo_q};
	assign next_cl = cur_q[0] ? 12'(pair >> 4) : 12'(pair & ENTRY_MASK);

	assign cl_off   = 32'(cur_q) - 32'd2;
	assign mul_full = cl_off * {24'd0, eff_spc};

	assign sts.op        = in_data.op;
	assign sts.start_end = in_data.start_cluster >= END_MARK;
	assign sts.ended     = ended_q;
	assign sts.wrap      = ({1'b0, sic_q} + 8'd1) >= eff_spc;
	assign sts.next_end  = next_cl >= END_MARK;
	assign sts.out_busy  = out_valid_q & ~out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsl_q <= DATA_START_RST;
			spc_q <= SPC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DATA_START: dsl_q <= cfg_wdata;
				REG_SPC:        spc_q <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			sic_q   <= '0;
			ended_q <= 1'b1;
		end else begin
			if (cmd.do_start) begin
				cur_q   <= in_data.start_cluster;
				sic_q   <= '0;
				ended_q <= sts.start_end;
			end
			if (cmd.sec_inc) begin
				sic_q <= sic_q + 7'd1;
			end
			if (cmd.sec_clr) begin
				sic_q <= '0;
			end
			if (cmd.take_next) begin
				cur_q   <= next_cl;
				ended_q <= sts.next_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_lo | cmd.rd_hi) begin
			rd_ok_q <= rd_ok;
		end
		if (cmd.rd_hi) begin
			lo_q <= rbyte;
		end
		if (cmd.mul) begin
			prod_q <= mul_full;
		end
		if (cmd.sum) begin
			lba_q <= dsl_q + prod_q + 32'(sic_q);
		end else if (cmd.lba_clr) begin
			lba_q <= '0;
		end
		if (cmd.out_load) begin
			out_q.sector_lba   <= lba_q;
			out_q.cluster_now  <= cur_q;
			out_q.end_of_chain <= ended_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/core/fat12_cluster_chain_sector_walker.sv */
`timescale 1ns / 1ps
// FAT12 cluster chain sector walker: loads a FAT12 table byte by byte and steps
// one file's chain sector by sector, one result word per input word.
// Depends on fat12w_pkg, fat12w_ctrl, fat12w_dp, fat12w_ram.
//
// One input word at a time. A table load goes straight to its result word; a start or an
// advance within a cluster runs one registered 32x8 multiply, then the LBA add; and
// an advance that crosses into the next cluster first fetches the next entry with the
// two sequential reads of the single-read-port table RAM. The output register lets
// the next word in while a result waits. No clearing pass: table bytes read
// before they are written are undefined.
module fat12_cluster_chain_sector_walker #(
	parameter int TABLE_BYTES = fat12w_pkg::TABLE_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fat12w_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fat12w_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  fat12w_pkg::in_word_t             in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output fat12w_pkg::out_word_t            out_data
);
	import fat12w_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fat12w_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fat12w_dp #(
		.TABLE_BYTES (TABLE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_eoc_lba_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.end_of_chain) |-> (out_data.sector_lba == 32'd0))
		else $error("end of chain with nonzero LBA");

	a_live_cluster: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.end_of_chain) |-> (out_data.cluster_now < END_MARK))
		else $error("live chain reports end-mark cluster");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word accepted while busy");

	a_read_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_hi |-> $past(cmd.rd_lo))
		else $error("high table byte read without low byte read");

endmodule

/* tb/sv/fat12w_chain_checker.sv */
`timescale 1ns / 1ps
// Checker for the FAT12 cluster chain sector walker: watches config, input and output words,
// predicts each result from its own copy of the table and walk state, and counts mismatches.
// Depends on fat12w_pkg.
module fat12w_chain_checker
	import fat12w_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_word_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_word_t            out_data,
	output int                   fail_count,
	output int                   pending
);

	logic [7:0]  fat_bytes [TABLE_BYTES_DEF];
	logic [11:0] walk_cluster;
	logic [6:0]  walk_sector;
	logic        walk_ended;
	logic [31:0] data_start;
	logic [7:0]  spc_reg;
	out_word_t   sector_q [$];
	out_word_t   want;
	int          fails = 0;

	function automatic int spc_eff();
		if (spc_reg == 8'd0)
			return 1;
		if (spc_reg > SPC_MAX)
			return int'(SPC_MAX);
		return int'(spc_reg);
	endfunction

	function automatic logic [11:0] fat_entry(input logic [11:0] c);
		int          at;
		logic [15:0] pair;
		at   = (int'(c) * 3) / 2;
		pair = {fat_bytes[at + 1], fat_bytes[at]};
		return 12'((c[0] ? (pair >> 4) : pair) & ENTRY_MASK);
	endfunction

	function automatic logic [31:0] lba_now();
		return data_start + (32'(walk_cluster) - 32'd2) * 32'(spc_eff()) + 32'(walk_sector);
	endfunction

	function automatic out_word_t step_walk(input in_word_t w);
		out_word_t r;
		r.sector_lba = '0;
		case (w.op)
			OP_LOAD: begin
				if (int'(w.table_addr) < TABLE_BYTES_DEF)
					fat_bytes[w.table_addr] = w.table_byte;
			end
			OP_START: begin
				walk_cluster = w.start_cluster;
				walk_sector  = '0;
				walk_ended   = (w.start_cluster >= END_MARK);
				if (!walk_ended)
					r.sector_lba = lba_now();
			end
			OP_ADVANCE: begin
				if (!walk_ended) begin
					if (int'(walk_sector) + 1 >= spc_eff()) begin
						walk_sector  = '0;
						walk_cluster = fat_entry(walk_cluster);
					end else begin
						walk_sector = walk_sector + 7'd1;
					end
					if (walk_cluster >= END_MARK)
						walk_ended = 1'b1;
					else
						r.sector_lba = lba_now();
				end
			end
			default: ;
		endcase
		r.cluster_now  = walk_cluster;
		r.end_of_chain = walk_ended;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_cluster = '0;
			walk_sector  = '0;
			walk_ended   = 1'b1;
			data_start   = DATA_START_RST;
			spc_reg      = SPC_RST;
			sector_q.delete();
			pending    <= 0;
			fail_count <= fails;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DATA_START: data_start = cfg_wdata[31:0];
					REG_SPC:        spc_reg    = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				sector_q.push_back(step_walk(in_data));
			if (out_valid && out_ready) begin
				if (sector_q.size() == 0) begin
					$error("result word with nothing expected: %0h", out_data);
					fails++;
				end else begin
					want = sector_q.pop_front();
					if (out_data.sector_lba !== want.sector_lba) begin
						$error("sector_lba: expected %0h, got %0h",
							want.sector_lba, out_data.sector_lba);
						fails++;
					end
					if (out_data.cluster_now !== want.cluster_now) begin
						$error("cluster_now: expected %0h, got %0h",
							want.cluster_now, out_data.cluster_now);
						fails++;
					end
					if (out_data.end_of_chain !== want.end_of_chain) begin
						$error("end_of_chain: expected %0b, got %0b",
							want.end_of_chain, out_data.end_of_chain);
						fails++;
					end
				end
			end
			pending    <= sector_q.size();
			fail_count <= fails;
		end
	end

endmodule

/* tb/sv/fat12_cluster_chain_sector_walker_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the FAT12 cluster chain sector walker: clock, reset, config phases and
// input/output word stimulus; the verdict comes from fat12w_chain_checker.
// Depends on fat12w_pkg, fat12w_chain_checker and the walker RTL.
module fat12_cluster_chain_sector_walker_tb;
	import fat12w_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	in_word_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_word_t            out_data;
	int                   fail_count;
	int                   pending;

	// stimulus-side view of the table and walk, so no unwritten entry is ever read
	logic [7:0]  shadow_fat [TABLE_BYTES_DEF];
	bit          shadow_set [TABLE_BYTES_DEF];
	logic [11:0] trk_cluster;
	int          trk_sector;
	bit          trk_ended;
	int          trk_spc;
	bit          calm;
	bit          stall_ask;

	fat12_cluster_chain_sector_walker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	fat12w_chain_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("fat12_cluster_chain_sector_walker test failed");
		$finish;
	end

	// receiver: random back-pressure (none while calm), or one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_ask) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				stall_ask = 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 26);
			end
		end
	end

	function automatic in_word_t noise_word(input logic [1:0] op);
		in_word_t w;
		w.op            = op;
		w.table_addr    = 13'($urandom);
		w.table_byte    = 8'($urandom);
		w.start_cluster = 12'($urandom);
		return w;
	endfunction

	function automatic logic [11:0] pick_cluster();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 12'($urandom_range(END_MARK, 12'hFFF));
		if (r < 25)
			return 12'($urandom_range(1));
		if (r < 65)
			return 12'($urandom_range(2, 40));
		return 12'($urandom_range(4095));
	endfunction

	task automatic send_word(input in_word_t w);
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_config(input logic [31:0] start_lba, input logic [7:0] spc);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= REG_DATA_START;
		cfg_wdata <= start_lba;
		@(posedge clk);
		cfg_index <= REG_SPC;
		cfg_wdata <= 32'(spc);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		trk_spc = (spc == 8'd0) ? 1 : (spc > SPC_MAX) ? int'(SPC_MAX) : int'(spc);
	endtask

	task automatic load_byte(input logic [12:0] addr, input logic [7:0] val);
		in_word_t w;
		w            = noise_word(OP_LOAD);
		w.table_addr = addr;
		w.table_byte = val;
		send_word(w);
		shadow_fat[addr] = val;
		shadow_set[addr] = 1'b1;
	endtask

	// write the entry of cluster c with a fresh next pointer if any byte of it is unset
	task automatic ensure_entry(input logic [11:0] c);
		int          at;
		logic [11:0] nxt;
		at = (int'(c) * 3) / 2;
		if (!shadow_set[at] || !shadow_set[at + 1]) begin
			nxt = pick_cluster();
			if (c[0]) begin
				load_byte(13'(at), {nxt[3:0], 4'($urandom)});
				load_byte(13'(at + 1), nxt[11:4]);
			end else begin
				load_byte(13'(at), nxt[7:0]);
				load_byte(13'(at + 1), {4'($urandom), nxt[11:8]});
			end
		end
	endtask

	task automatic start_chain(input logic [11:0] c);
		in_word_t w;
		w               = noise_word(OP_START);
		w.start_cluster = c;
		send_word(w);
		trk_cluster = c;
		trk_sector  = 0;
		trk_ended   = (c >= END_MARK);
	endtask

	task automatic advance();
		int          at;
		logic [15:0] pair;
		if (!trk_ended && trk_sector + 1 >= trk_spc)
			ensure_entry(trk_cluster);
		send_word(noise_word(OP_ADVANCE));
		if (!trk_ended) begin
			if (trk_sector + 1 >= trk_spc) begin
				trk_sector  = 0;
				at          = (int'(trk_cluster) * 3) / 2;
				pair        = {shadow_fat[at + 1], shadow_fat[at]};
				trk_cluster = trk_cluster[0] ? pair[15:4] : pair[11:0];
			end else begin
				trk_sector++;
			end
			if (trk_cluster >= END_MARK)
				trk_ended = 1'b1;
		end
	endtask

	task automatic run_random(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 15)
				start_chain(pick_cluster());
			else if (r < 75)
				advance();
			else if (r < 93)
				load_byte(13'($urandom_range(8191)), 8'($urandom));
			else
				send_word(noise_word(OP_UNUSED));
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		calm        = 1'b0;
		stall_ask   = 1'b0;
		trk_cluster = '0;
		trk_sector  = 0;
		trk_ended   = 1'b1;
		trk_spc     = int'(SPC_RST);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: held chain after reset, unused op, table extremes, end marks, wrap
		advance();
		send_word(noise_word(OP_UNUSED));
		load_byte(13'h0000, 8'hFF);
		load_byte(13'h1FFF, 8'h00);
		load_byte(13'h1FFF, 8'hFF);
		load_byte(13'h0000, 8'h00);
		start_chain(12'hFFF);
		advance();
		start_chain(END_MARK);
		start_chain(12'hFF7);
		advance();
		start_chain(12'h000);
		advance();
		start_chain(12'h001);
		advance();
		start_chain(12'h002);
		advance();
		advance();
		run_random(60);

		write_config(32'hFFFF_FFFF, SPC_MAX);
		start_chain(12'($urandom_range(2, 40)));
		repeat (130) advance();
		run_random(40);

		write_config(32'h0000_0000, 8'd0);
		calm = 1'b1;
		run_random(60);
		calm = 1'b0;

		write_config(32'($urandom), 8'hFF);
		stall_ask = 1'b1;
		run_random(30);
		wait_drained();
		run_random(40);

		write_config(32'($urandom), 8'($urandom_range(2, 5)));
		run_random(70);

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("fat12_cluster_chain_sector_walker test passed");
		end else begin
			$display("fat12_cluster_chain_sector_walker test failed");
		end
		$finish;
	end

endmodule
